@@ src/rdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

   typedef logic [4:0] digit_type;
   typedef logic [6:0] char_type;

   localparam digit_type RADIX_MIN  = 5'd2;
   localparam digit_type RADIX_MAX  = 5'd20;
   localparam digit_type DIGIT_TEN  = 5'd10;
   localparam char_type  ASCII_ZERO = 7'h30;
   localparam char_type  ASCII_A    = 7'h41;

   // map a digit value to its ASCII character
   function automatic char_type digit_ascii(input digit_type d);
      char_type c;
      if (d < DIGIT_TEN) begin
         c = ASCII_ZERO + {2'b00, d};
      end else begin
         c = ASCII_A + {2'b00, d - DIGIT_TEN};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ src/radix_digit_converter.sv @@
// Integer to base-N digit string converter.
// Input channel (req_): one word per conversion, a signed number and a base.
// Output channel (rsp_): one word per ASCII digit, most significant first,
// tlast on the final one. A base outside 2..20 gives a single word with the
// bad-base flag; a number that is zero or negative gives a single word with
// the empty flag; flagged words carry a zero character and tlast.
// The number used is its low W = min(DATA_WIDTH, 32) bits, two's complement.
// Each digit comes from one pass of a bit-serial restoring divider, one
// quotient bit per cycle. Digits are pushed onto a shift-register stack,
// then popped to the output register one per cycle while the receiver takes them.
// A flagged word passes from acceptance through the emit state into the
// output register. A new word is taken once the last result of the
// previous one sits in the output register.
// Reset returns the controller to idle and clears the output valid.
// While the receiver stalls the output word holds and popping pauses.
`timescale 1ns / 1ps
`default_nettype none

module radix_digit_converter #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // [31:0] number, [36:32] radix, [39:37] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // [6:0] digit_char, [7] zero
   output logic             rsp_tlast,
   output logic [1:0]       rsp_tuser   // [0] empty_res, [1] bad_base
);

   localparam int VW    = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam int DEPTH = VW - 1;
   localparam int CW    = $clog2(VW);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [VW-1:0]             q_ff, q_in;
   rdc_pkg::digit_type        rem_ff, rem_in;
   rdc_pkg::digit_type        radix_ff, radix_in;
   logic [CW-1:0]             bit_cnt_ff, bit_cnt_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      bad_ff, bad_in;
   logic                      empty_ff, empty_in;
   rdc_pkg::digit_type        stack_ff [DEPTH];
   rdc_pkg::digit_type        stack_in [DEPTH];
   logic                      rsp_valid_ff, rsp_valid_in;
   rdc_pkg::char_type         rsp_char_ff, rsp_char_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [1:0]                rsp_user_ff, rsp_user_in;

   logic [5:0]                rem2;
   logic                      ge;
   rdc_pkg::digit_type        rem_step;
   logic [VW-1:0]             q_step;
   logic                      rsp_free;
   logic [VW-1:0]             num_v;
   rdc_pkg::digit_type        req_radix;
   logic                      req_bad;
   logic                      req_empty;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign num_v     = req_tdata[VW-1:0];
   assign req_radix = req_tdata[36:32];
   assign req_bad   = (req_radix < rdc_pkg::RADIX_MIN) || (req_radix > rdc_pkg::RADIX_MAX);
   assign req_empty = num_v[VW-1] || (num_v == '0);

   // one restoring division step
   assign rem2     = {rem_ff, q_ff[VW-1]};
   assign ge       = (rem2 >= {1'b0, radix_ff});
   assign rem_step = ge ? 5'(rem2 - {1'b0, radix_ff}) : rem2[4:0];
   assign q_step   = {q_ff[VW-2:0], ge};
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      radix_in     = radix_ff;
      bit_cnt_in   = bit_cnt_ff;
      cnt_in       = cnt_ff;
      bad_in       = bad_ff;
      empty_in     = empty_ff;
      stack_in     = stack_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               radix_in   = req_radix;
               q_in       = num_v;
               rem_in     = '0;
               bit_cnt_in = '0;
               cnt_in     = '0;
               bad_in     = req_bad;
               empty_in   = !req_bad && req_empty;
               state_in   = (req_bad || req_empty) ? ST_EMIT : ST_DIV;
            end
         end
         ST_DIV: begin
            q_in       = q_step;
            rem_in     = rem_step;
            bit_cnt_in = CW'(bit_cnt_ff + 1'b1);
            if (bit_cnt_ff == CW'(VW - 1)) begin
               // push the remainder as the next digit
               for (int i = 1; i < DEPTH; i++) begin
                  stack_in[i] = stack_ff[i-1];
               end
               stack_in[0] = rem_step;
               cnt_in      = CW'(cnt_ff + 1'b1);
               bit_cnt_in  = '0;
               rem_in      = '0;
               if (q_step == '0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (bad_ff || empty_ff) begin
                  rsp_char_in = '0;
                  rsp_last_in = 1'b1;
                  rsp_user_in = {bad_ff, empty_ff};
                  state_in    = ST_IDLE;
               end else begin
                  // pop the most significant digit
                  rsp_char_in = rdc_pkg::digit_ascii(stack_ff[0]);
                  rsp_last_in = (cnt_ff == CW'(1));
                  rsp_user_in = '0;
                  for (int i = 0; i < DEPTH - 1; i++) begin
                     stack_in[i] = stack_ff[i+1];
                  end
                  cnt_in = CW'(cnt_ff - 1'b1);
                  if (cnt_ff == CW'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bit_cnt_ff   <= '0;
         cnt_ff       <= '0;
         bad_ff       <= 1'b0;
         empty_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_cnt_ff   <= bit_cnt_in;
         cnt_ff       <= cnt_in;
         bad_ff       <= bad_in;
         empty_ff     <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      stack_ff    <= stack_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

`default_nettype wire

@@ src/rdc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rdc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic [1:0]  rsp_tuser
);

   // drop any output word at reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // hold a stalled word
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled output word changed");

   a_flag_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != 2'b00) |-> rsp_tlast && (rsp_tdata == 8'd0)
         && (rsp_tuser != 2'b11))
      else $error("flagged word malformed");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == 2'b00) |->
         ((rsp_tdata >= 8'h30) && (rsp_tdata <= 8'h39))
         || ((rsp_tdata >= 8'h41) && (rsp_tdata <= 8'h4A)))
      else $error("digit character out of range");

   // take one word at a time
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
`default_nettype none

module testbench;

   localparam int W            = 32;
   localparam int RANDOM_WORDS = 450;
   localparam int CALM_TAIL    = 40;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 64;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [31:0]        number;
      rdc_pkg::digit_type radix;
   } conv_req_type;

   typedef struct packed {
      rdc_pkg::char_type digit_char;
      logic              last;
      logic              empty_res;
      logic              bad_base;
   } digit_word_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // [31:0] number, [36:32] radix, [39:37] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [6:0] digit_char, [7] zero
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;   // [0] empty_res, [1] bad_base

   conv_req_type   pending_convs[$];
   digit_word_type expected_digits[$];

   bit req_fire;
   bit calm;
   int send_gap;
   int recv_stall;
   int convs_sent;
   int words_checked;
   int mismatches;
   int idle_cycles;
   int n_digit_runs;
   int n_empty;
   int n_bad;

   radix_digit_converter #(.DATA_WIDTH(W)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void predict_digits(input conv_req_type r);
      logic [31:0]        v;
      rdc_pkg::digit_type d;
      rdc_pkg::digit_type stack[$];
      digit_word_type     dw;
      int                 n;
      v  = r.number;
      dw = '0;
      dw.last = 1'b1;
      if (r.radix < rdc_pkg::RADIX_MIN || r.radix > rdc_pkg::RADIX_MAX) begin
         dw.bad_base = 1'b1;
         expected_digits.push_back(dw);
         n_bad++;
      end else if (v[W-1] || v == 0) begin
         dw.empty_res = 1'b1;
         expected_digits.push_back(dw);
         n_empty++;
      end else begin
         n = 0;
         while (v != 0 && n < W - 1) begin
            stack.push_front(rdc_pkg::digit_type'(v % r.radix));
            v = v / r.radix;
            n++;
         end
         foreach (stack[k]) begin
            d = stack[k];
            dw.digit_char = (d < rdc_pkg::DIGIT_TEN)
               ? rdc_pkg::ASCII_ZERO + rdc_pkg::char_type'(d)
               : rdc_pkg::ASCII_A + rdc_pkg::char_type'(d - rdc_pkg::DIGIT_TEN);
            dw.last = (k == stack.size() - 1);
            expected_digits.push_back(dw);
         end
         n_digit_runs++;
      end
   endfunction

   task automatic add_conv(input logic [31:0] number, input rdc_pkg::digit_type radix);
      conv_req_type r;
      r.number = number;
      r.radix  = radix;
      pending_convs.push_back(r);
   endtask

   // monitor: check results, predict on accepted words, watchdog
   always @(posedge clock) begin : rsp_monitor
      digit_word_type got;
      digit_word_type want;
      conv_req_type   req;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.digit_char = rsp_tdata[6:0];
            got.last       = rsp_tlast;
            got.empty_res  = rsp_tuser[0];
            got.bad_base   = rsp_tuser[1];
            words_checked++;
            if (expected_digits.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected word: char %h last %b empty %b bad %b",
                           got.digit_char, got.last, got.empty_res, got.bad_base);
            end else begin
               want = expected_digits.pop_front();
               if (got.digit_char !== want.digit_char || got.last !== want.last ||
                   got.empty_res !== want.empty_res || got.bad_base !== want.bad_base) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("mismatch %0t exp/act: char %h/%h last %b/%b empty %b/%b bad %b/%b",
                              $time,
                              want.digit_char, got.digit_char, want.last, got.last,
                              want.empty_res, got.empty_res, want.bad_base, got.bad_base);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req.number = req_tdata[31:0];
            req.radix  = req_tdata[36:32];
            predict_digits(req);
            convs_sent++;
            req_fire = 1'b1;
         end
         calm = pending_convs.size() < CALM_TAIL;
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // sender: hold the word until taken, then advance or pause
   always @(negedge clock) begin : req_driver
      conv_req_type item;
      if (!reset) begin
         if (!req_tvalid || req_fire) begin
            req_fire = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_convs.size() > 0) begin
               item = pending_convs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, item.radix, item.number};
               if (!calm && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 9);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stall bursts
   always @(negedge clock) begin : rsp_driver
      if (!reset) begin
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0)
               recv_stall = $urandom_range(1, 9);
         end
      end
   end

   initial begin : stimulus
      conv_req_type r;
      int           sel;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;

      add_conv(32'd1, rdc_pkg::RADIX_MIN);
      add_conv(32'h7FFF_FFFF, rdc_pkg::RADIX_MIN);
      add_conv(32'h7FFF_FFFF, rdc_pkg::RADIX_MAX);
      add_conv(32'h7FFF_FFFF, 5'd16);
      add_conv(32'd19, rdc_pkg::RADIX_MAX);
      add_conv(32'd399, rdc_pkg::RADIX_MAX);
      add_conv(32'd10, 5'd11);
      add_conv(32'd1000, 5'd10);
      add_conv(32'd12345, 5'd13);
      add_conv(32'd2186, 5'd3);
      add_conv(32'd823542, 5'd7);
      add_conv(32'd1, rdc_pkg::RADIX_MAX);
      add_conv(32'd0, 5'd10);
      add_conv(32'hFFFF_FFFF, 5'd10);
      add_conv(32'h8000_0000, rdc_pkg::RADIX_MIN);
      add_conv(32'd0, rdc_pkg::RADIX_MAX);
      add_conv(32'd12345, 5'd0);
      add_conv(32'd12345, 5'd1);
      add_conv(32'd12345, 5'd21);
      add_conv(32'h7FFF_FFFF, 5'd31);
      add_conv(32'h8000_0000, 5'd31);
      add_conv(32'd0, 5'd0);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         sel      = $urandom_range(0, 19);
         r.number = $urandom;
         r.radix  = rdc_pkg::digit_type'($urandom_range(rdc_pkg::RADIX_MIN,
                                                         rdc_pkg::RADIX_MAX));
         if (sel < 14) begin
            r.number[31] = 1'b0;
            r.number     = r.number >> $urandom_range(0, 30);
            if (r.number == 0)
               r.number = 32'd1;
         end else if (sel == 14) begin
            r.number = '0;
         end else if (sel == 15) begin
            r.number[31] = 1'b1;
         end else if (sel < 18) begin
            r.radix = $urandom_range(0, 1) ? rdc_pkg::digit_type'($urandom_range(0, 1))
                                           : rdc_pkg::digit_type'($urandom_range(21, 31));
         end else begin
            r.radix = rdc_pkg::digit_type'($urandom);
         end
         pending_convs.push_back(r);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_convs.size() != 0 || req_tvalid || expected_digits.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d conversions sent, %0d result words checked", convs_sent, words_checked);
      $display("%0d digit runs, %0d empty, %0d bad base, %0d mismatches",
               n_digit_runs, n_empty, n_bad, mismatches);
      if (mismatches == 0 && expected_digits.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
